// ===== sv/nws_pkg.sv =====
// Package: request, result and table entry types for the nearest waypoint search.
`default_nettype none
package nws_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned SlotW   = 7;
  localparam int unsigned SqW     = 33;
  localparam int unsigned DistW   = 34;
  localparam int unsigned CountW  = 8;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [SlotW-1:0]         entry_index;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] nearest_index;
    logic             found;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_t;

endpackage
`default_nettype wire

// ===== sv/nws_table.sv =====
// Waypoint table: one write port, one registered read port.
`default_nettype none
module nws_table import nws_pkg::*; #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire point_t           wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      point_t           rd_data_o
);

  point_t mem [Depth];
  point_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

// ===== sv/nws_dist_unit.sv =====
// Shared difference-and-square unit with registered output.
`default_nettype none
module nws_dist_unit import nws_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [CoordW-1:0] a_i,
  input  wire logic signed [CoordW-1:0] b_i,
  output      logic [SqW-1:0]           sq_o
);

  logic signed [CoordW:0]     diff;
  logic signed [2*CoordW+1:0] prod;
  logic [SqW-1:0]             sq_q;

  assign diff = (CoordW+1)'(a_i) - (CoordW+1)'(b_i);
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    sq_q <= prod[SqW-1:0];
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

// ===== sv/nearest_waypoint_search.sv =====
// Nearest waypoint search: top level with sequencer, count register and APB port.
//
// Requests enter on req_i when start is high and busy is low. A write request
// (func = 0) stores (pos_x, pos_y) at entry_index and gives no result; busy
// stays low. A query request (func = 1) scans the first point_count entries
// (saturated to the table size) through one shared difference-and-square
// unit, per entry in the steps square dx, square dy, add and compare. busy is
// high meanwhile. The result shows on rsp_o with result_valid_o high for one
// cycle, registered from the last compare step, or in the cycle after the
// query was taken for an empty table; after a scan busy falls as it shows.
// The receiver cannot stall: the strobe is not held. point_count is written
// over the APB port at byte address 0 while the block is idle, a rule for the
// user that the block itself does not enforce; reads return it. Reset clears
// the sequencer and point_count; the table holds whatever was last written.
`default_nettype none
module nearest_waypoint_search import nws_pkg::*; #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire req_t        req_i,
  output      logic        result_valid_o,
  output      rsp_t        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned SlotLimit = (MAX_POINTS < 128) ? MAX_POINTS : 128;
  localparam int unsigned AddrW     = $clog2(MAX_POINTS);
  localparam int unsigned IdxW      = $clog2(SlotLimit);
  localparam int unsigned CntW      = $clog2(SlotLimit + 1);
  localparam logic        RegPointCount = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQX  = 4'b0010,
    S_SQY  = 4'b0100,
    S_CMP  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   point_count_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [DistW-1:0]    best_q, best_d;
  logic [SqW-1:0]      sqx_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic                res_valid_q, res_valid_d;
  rsp_t                rsp_q, rsp_d;

  logic                accept;
  logic                wr_en;
  logic [AddrW+SlotW-1:0] wr_addr_wide;
  logic [AddrW+IdxW-1:0]  rd_addr_wide;
  point_t              rd_data;
  logic signed [CoordW-1:0] op_a, op_b;
  logic [SqW-1:0]      sq;
  logic [DistW-1:0]    dist_sum;
  logic                take;
  logic                last;
  logic [SlotW+IdxW-1:0] idx_wide;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPointCount) ? {{(32-CountW){1'b0}}, point_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegPointCount)) begin
      point_count_q <= pwdata[CountW-1:0];
    end
  end

  assign accept = start && !busy;
  assign wr_en  = accept && (req_i.func == FuncWrite) &&
                  (32'(req_i.entry_index) < MAX_POINTS);
  assign wr_addr_wide = {{AddrW{1'b0}}, req_i.entry_index};
  assign rd_addr_wide = {{AddrW{1'b0}}, idx_d};

  nws_table #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr_wide[AddrW-1:0]),
    .wr_data_i ({req_i.pos_y, req_i.pos_x}),
    .rd_addr_i (rd_addr_wide[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  assign op_a = (state_q == S_SQX) ? rd_data.x : rd_data.y;
  assign op_b = (state_q == S_SQX) ? px_q : py_q;

  nws_dist_unit u_dist (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .sq_o  (sq)
  );

  assign dist_sum = {1'b0, sqx_q} + {1'b0, sq};
  assign take = (idx_q == '0) || (dist_sum < best_q);
  assign last = (CntW'({1'b0, idx_q}) + CntW'(1)) == cnt_q;
  assign idx_wide = {{SlotW{1'b0}}, idx_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_valid_d = 1'b0;
    rsp_d       = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.func == FuncQuery)) begin
          cnt_d = (point_count_q > CountW'(SlotLimit)) ? CntW'(SlotLimit)
                                                       : CntW'(point_count_q);
          idx_d = '0;
          if (cnt_d == '0) begin
            res_valid_d = 1'b1;
            rsp_d       = '{nearest_index: '0, found: 1'b0};
          end else begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: state_d = S_CMP;
      S_CMP: begin
        if (take) begin
          best_d     = dist_sum;
          best_idx_d = idx_q;
        end
        if (last) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          rsp_d.found = 1'b1;
          rsp_d.nearest_index = take ? idx_wide[SlotW-1:0]
                                     : SlotW'({{SlotW{1'b0}}, best_idx_q});
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_SQX;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rsp_q      <= rsp_d;
    if (state_q == S_SQY) begin
      sqx_q <= sq;
    end
    if (accept) begin
      px_q <= req_i.pos_x;
      py_q <= req_i.pos_y;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign rsp_o          = rsp_q;

  property p_result_when_idle;
    @(posedge clk_i) disable iff (!rst_ni) res_valid_q |-> (state_q == S_IDLE);
  endproperty
  a_result_when_idle: assert property (p_result_when_idle)
    else $error("result strobe outside idle");

  property p_index_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && rsp_q.found) |-> (CntW'(rsp_q.nearest_index) < cnt_q);
  endproperty
  a_index_in_range: assert property (p_index_in_range)
    else $error("nearest index beyond scanned count");

  property p_empty_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && !rsp_q.found) |-> (rsp_q.nearest_index == '0);
  endproperty
  a_empty_zero: assert property (p_empty_zero)
    else $error("empty search with nonzero index");

  property p_sqy_to_cmp;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_SQY) |=> (state_q == S_CMP);
  endproperty
  a_sqy_to_cmp: assert property (p_sqy_to_cmp)
    else $error("sequencer skipped compare step");

endmodule
`default_nettype wire

// ===== sim/waypoint_search_checker.sv =====
// Checker for the nearest waypoint search: tracks table and count, predicts and compares results.
`timescale 1ns / 1ps
module waypoint_search_checker import nws_pkg::*; #(
  parameter logic [2:0] COUNT_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        result_valid_o,
  input  rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  localparam int unsigned TableDepth = 128;

  logic signed [CoordW-1:0] way_x [TableDepth];
  logic signed [CoordW-1:0] way_y [TableDepth];
  logic [CountW-1:0]        point_count_q;
  rsp_t                     nearest_q [$];
  rsp_t                     want;

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
  end

  // Exact squared distance, lowest slot wins a tie.
  function automatic rsp_t nearest_of(logic signed [CoordW-1:0] qx,
                                      logic signed [CoordW-1:0] qy);
    rsp_t                 r;
    int unsigned          n;
    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [DistW-1:0] d;
    logic signed [DistW-1:0] best;
    r    = '0;
    best = '0;
    n    = (point_count_q > TableDepth) ? TableDepth : point_count_q;
    if (n == 0) return r;
    r.found = 1'b1;
    for (int i = 0; i < n; i++) begin
      dx = $signed({way_x[i][CoordW-1], way_x[i]}) - $signed({qx[CoordW-1], qx});
      dy = $signed({way_y[i][CoordW-1], way_y[i]}) - $signed({qy[CoordW-1], qy});
      d  = dx * dx + dy * dy;
      if (i == 0 || d < best) begin
        best            = d;
        r.nearest_index = SlotW'(i);
      end
    end
    return r;
  endfunction

  task automatic mismatch(input string what, input longint unsigned exp_v,
                          input longint unsigned act_v);
    if (errors < 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nearest_q.delete();
      point_count_q = '0;
      pending       = 0;
    end else begin
      if (result_valid_o) begin
        results_seen++;
        if (nearest_q.size() == 0) begin
          mismatch("unexpected result, nearest_index", 0, rsp_o.nearest_index);
        end else begin
          want = nearest_q.pop_front();
          if (rsp_o.found !== want.found)
            mismatch("found", want.found, rsp_o.found);
          if (rsp_o.nearest_index !== want.nearest_index)
            mismatch("nearest_index", want.nearest_index, rsp_o.nearest_index);
        end
      end
      if (start && !busy) begin
        if (req_i.func == FuncWrite) begin
          way_x[req_i.entry_index] = req_i.pos_x;
          way_y[req_i.entry_index] = req_i.pos_y;
        end else begin
          nearest_q.push_back(nearest_of(req_i.pos_x, req_i.pos_y));
        end
      end
      if (psel && penable && pready && paddr == COUNT_ADDR) begin
        if (pwrite)
          point_count_q = pwdata[CountW-1:0];
        else if (prdata[CountW-1:0] !== point_count_q)
          mismatch("point_count readback", point_count_q, prdata[CountW-1:0]);
      end
      pending = nearest_q.size();
    end
  end

endmodule

// ===== sim/nearest_waypoint_search_test.sv =====
// Testbench top for the nearest waypoint search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module nearest_waypoint_search_test;
  import nws_pkg::*;

  localparam logic [2:0] COUNT_ADDR = 3'd0;
  localparam int         LIMIT      = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        result_valid_o;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int          results_seen;
  int          cycle_count;
  int          idle_pct;
  int unsigned cur_count;
  int          n_writes;
  int          n_queries;
  int          n_settings;

  nearest_waypoint_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  waypoint_search_checker #(.COUNT_ADDR(COUNT_ADDR)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .errors         (errors),
    .pending        (pending),
    .results_seen   (results_seen)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("nearest_waypoint_search_test: FAIL");
      $finish;
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return CoordW'($urandom);
    if (k < 85) return CoordW'(int'($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Holds start until the request is taken; optional gap with noise on req_i first.
  task automatic send_req(input req_t r);
    logic [63:0] noise;
    if ($urandom_range(0, 99) < idle_pct) begin
      noise = {$urandom, $urandom};
      start <= 1'b0;
      req_i <= noise[$bits(req_t)-1:0];
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (r.func == FuncWrite) n_writes++;
    else n_queries++;
  endtask

  task automatic send_write(input int unsigned slot, input logic signed [CoordW-1:0] x,
                            input logic signed [CoordW-1:0] y);
    req_t r;
    r.func        = FuncWrite;
    r.entry_index = SlotW'(slot);
    r.pos_x       = x;
    r.pos_y       = y;
    send_req(r);
  endtask

  task automatic send_query(input logic signed [CoordW-1:0] x,
                            input logic signed [CoordW-1:0] y);
    req_t r;
    r.func        = FuncQuery;
    r.entry_index = SlotW'($urandom);
    r.pos_x       = x;
    r.pos_y       = y;
    send_req(r);
  endtask

  task automatic send_random();
    req_t        r;
    int unsigned span;
    span   = (cur_count > 128) ? 128 : cur_count;
    r.func = ($urandom_range(0, 99) < 40) ? FuncWrite : FuncQuery;
    if (r.func == FuncWrite && span > 0 && $urandom_range(0, 99) < 70)
      r.entry_index = SlotW'($urandom_range(0, span - 1));
    else
      r.entry_index = SlotW'($urandom);
    r.pos_x = rand_coord();
    r.pos_y = rand_coord();
    send_req(r);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= COUNT_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain all outstanding searches, then let the write path finish.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count(input int unsigned v);
    settle();
    apb_access(1'b1, 32'(v));
    apb_access(1'b0, 32'd0);
    cur_count = v;
    n_settings++;
  endtask

  initial begin
    int unsigned v;
    start      = 1'b0;
    req_i      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 26;
    cur_count  = 0;
    n_writes   = 0;
    n_queries  = 0;
    n_settings = 0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, 32'd0);

    // empty table
    send_query(16'sd0, 16'sd0);
    send_query(-16'sd32768, 16'sd32767);
    send_write(0, -16'sd32768, -16'sd32768);
    send_write(1, 16'sd32767, 16'sd32767);
    send_write(2, 16'sd0, 16'sd0);
    send_write(3, -16'sd32768, -16'sd32768);
    send_write(127, 16'sd32767, -16'sd32768);

    // single entry, largest distance
    set_count(1);
    send_query(16'sd32767, 16'sd32767);
    send_query(-16'sd32768, -16'sd32768);

    // ties go to the lowest slot
    set_count(4);
    send_query(16'sd32767, 16'sd32767);
    send_query(-16'sd32768, -16'sd32768);
    send_query(-16'sd32768, 16'sd32767);
    send_query(16'sd32767, -16'sd32768);
    send_query(16'sd1, 16'sd1);
    send_query(16'sd0, -16'sd1);
    send_write(1, 16'sd0, 16'sd0);
    send_query(16'sd5, 16'sd5);

    // fill the whole table so any count is legal
    for (int s = 0; s < 128; s++) send_write(s, rand_coord(), rand_coord());

    for (int seg = 0; seg < 14; seg++) begin
      idle_pct = (seg < 5) ? 26 : (seg < 10) ? 51 : 0;
      case (seg)
        0: v = 255;
        1: v = 0;
        2: v = 128;
        3: v = 129;
        default: begin
          case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = $urandom_range(128, 255);
            2, 3:    v = $urandom_range(17, 64);
            default: v = $urandom_range(1, 16);
          endcase
        end
      endcase
      set_count(v);
      repeat (112) send_random();
    end

    settle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d waypoint writes and %0d nearest queries over %0d count settings.",
             n_writes, n_queries, n_settings);
    $display("Checked %0d search results, %0d mismatches, %0d left outstanding.",
             results_seen, errors, pending);
    if (errors == 0 && pending == 0)
      $display("nearest_waypoint_search_test: PASS");
    else
      $display("nearest_waypoint_search_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/nws_pkg.sv
sv/nws_table.sv
sv/nws_dist_unit.sv
sv/nearest_waypoint_search.sv
sim/waypoint_search_checker.sv
sim/nearest_waypoint_search_test.sv
